/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
// Each macro samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Whenever the first expression holds, the second must hold in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Whenever the first expression holds, the second must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/itwt_pkg.sv */
// ----------------------------------------------------------------------------
// itwt_pkg: shared types, constants and functions
// Token codes, decimal digit types and the single-digit extraction step used
// by the integer-to-word-token pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itwt_pkg;

	// Field widths.
	localparam int unsigned VALUE_W = 31;
	localparam int unsigned WORD_W  = 5;
	localparam int unsigned NDIGITS = 10;
	localparam int unsigned POW_W   = 34;

	// Token codes.
	localparam logic [WORD_W-1:0] TOK_ZERO     = 5'd0;
	localparam logic [WORD_W-1:0] TOK_TEN      = 5'd10;
	localparam logic [WORD_W-1:0] TOK_TWENTY   = 5'd20;
	localparam logic [WORD_W-1:0] TOK_HUNDRED  = 5'd28;
	localparam logic [WORD_W-1:0] TOK_THOUSAND = 5'd29;
	localparam logic [WORD_W-1:0] TOK_MILLION  = 5'd30;
	localparam logic [WORD_W-1:0] TOK_BILLION  = 5'd31;

	// Token slots: four groups of five slots each.
	localparam int unsigned NGROUPS  = 4;
	localparam int unsigned GSLOTS   = 5;
	localparam int unsigned NSLOTS   = NGROUPS * GSLOTS;

	// Depth of the queue between the digit pipeline and the token emitter.
	localparam int unsigned QDEPTH   = 2;

	// Powers of ten, index is the decimal position.
	localparam logic [POW_W-1:0] POW10 [NDIGITS] = '{
		34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
		34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
	};

	// Ten decimal digits, index 9 is the most significant.
	typedef logic [NDIGITS-1:0][3:0] digits_t;

	// One digit extraction result.
	typedef struct packed {
		logic [3:0]         digit;
		logic [VALUE_W-1:0] rem;
	} dstep_t;

	// Item passed from the digit pipeline into the queue.
	typedef struct packed {
		logic    vld;
		digits_t digits;
	} f2q_t;

	// Head of the queue as seen by the token emitter.
	typedef struct packed {
		logic    vld;
		digits_t digits;
	} q2b_t;

	// Takes out the digit at the given decimal position of a remainder that
	// is known to lie below ten times that position's power of ten.
	function automatic dstep_t digit_step(input logic [VALUE_W-1:0] r,
					      input logic [3:0] pos);
		dstep_t           res;
		logic [POW_W-1:0] sub;
		logic [POW_W-1:0] cand;
		res.digit = '0;
		sub       = '0;
		for (int d = 1; d < 10; d++) begin
			cand = POW_W'(d) * POW10[pos];
			if ({3'b000, r} >= cand) begin
				res.digit = 4'(d);
				sub       = cand;
			end
		end
		res.rem = VALUE_W'({3'b000, r} - sub);
		return res;
	endfunction

endpackage

`default_nettype wire

/* hdl/integer_to_word_tokens.sv */
// ----------------------------------------------------------------------------
// integer_to_word_tokens: English word tokens of a 31-bit integer
// Top level: digit pipeline, item queue and token emitter.
// ----------------------------------------------------------------------------
// A value is taken at a rising edge where start is high and busy is low, and
// a new value may be given in every such cycle. Its tokens leave one per
// cycle on word, each marked by strobe for exactly one cycle, with last high
// on the final token of the value; the receiver cannot hold them off. A value
// gives 1 to 16 tokens, and the token emitter sends one per cycle, going on
// to the next queued value once the last token of one has gone; the
// sustained rate is one token per cycle. When the emitter is free, the first
// token of a value goes from the edge that takes it, which loads the first of
// the 9 digit stages, through the queue and into the output register. busy
// rises when the last digit stage holds an item that the two-entry queue
// cannot take, and the whole digit pipeline then holds.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_word_tokens (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [itwt_pkg::VALUE_W-1:0]  value,
	output logic                               strobe,
	output logic [itwt_pkg::WORD_W-1:0]        word,
	output logic                               last
);

	itwt_pkg::f2q_t q_in;
	itwt_pkg::q2b_t head;
	logic           q_ready;
	logic           pop;

	// Front: digit extraction.
	itwt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.value   (value),
		.busy    (busy),
		.q_ready (q_ready),
		.q_in    (q_in)
	);

	// Queue between the front and the emitter.
	itwt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_in    (q_in),
		.q_ready (q_ready),
		.head    (head),
		.pop     (pop)
	);

	// Back: token emission.
	itwt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.strobe (strobe),
		.word   (word),
		.last   (last)
	);

endmodule

`default_nettype wire

/* hdl/itwt_front.sv */
// ----------------------------------------------------------------------------
// itwt_front: decimal digit pipeline
// Accepts one value per cycle unless stalled, takes out one decimal digit per
// stage, most significant first, and hands the ten digits to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module itwt_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [itwt_pkg::VALUE_W-1:0]   value,
	output logic                                busy,
	input  wire logic                           q_ready,
	output itwt_pkg::f2q_t                      q_in
);

	localparam int unsigned NSTG = itwt_pkg::NDIGITS - 1;

	logic                          stg_vld_s [1:NSTG];
	logic [itwt_pkg::VALUE_W-1:0]  stg_rem_s [1:NSTG];
	itwt_pkg::digits_t             stg_dig_s [1:NSTG];
	itwt_pkg::dstep_t              step      [1:NSTG];
	itwt_pkg::digits_t             dig_nxt   [1:NSTG];
	logic                          stall;
	logic                          accept;

	// The pipeline holds as a whole when its last item cannot enter the queue.
	assign stall  = stg_vld_s[NSTG] && !q_ready;
	assign busy   = stall;
	assign accept = start && !busy;

	// Digit extraction for each stage, and the digits each stage will hold.
	always_comb begin
		step[1]    = itwt_pkg::digit_step(value, 4'(itwt_pkg::NDIGITS - 1));
		dig_nxt[1] = '0;
		dig_nxt[1][itwt_pkg::NDIGITS-1] = step[1].digit;
		for (int k = 2; k <= NSTG; k++) begin
			step[k] = itwt_pkg::digit_step(stg_rem_s[k-1],
						       4'(itwt_pkg::NDIGITS - k));
			dig_nxt[k] = stg_dig_s[k-1];
			dig_nxt[k][itwt_pkg::NDIGITS-k] = step[k].digit;
		end
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) stg_vld_s[k] <= 1'b0;
		end else if (!stall) begin
			stg_vld_s[1] <= accept;
			for (int k = 2; k <= NSTG; k++) stg_vld_s[k] <= stg_vld_s[k-1];
		end
	end

	// Remainders and the digits found so far.
	always_ff @(posedge clk) begin
		if (!stall) begin
			for (int k = 1; k <= NSTG; k++) begin
				stg_rem_s[k] <= step[k].rem;
				stg_dig_s[k] <= dig_nxt[k];
			end
		end
	end

	// After the last stage the remainder is the units digit.
	always_comb begin
		q_in.vld       = stg_vld_s[NSTG];
		q_in.digits    = stg_dig_s[NSTG];
		q_in.digits[0] = stg_rem_s[NSTG][3:0];
	end

	`ASSERT_NEXT(a_stall_holds, stall, $stable(stg_dig_s[NSTG]), "front: stalled item changed")
	`ASSERT_ALWAYS(a_units_digit, !stg_vld_s[NSTG] || (stg_rem_s[NSTG] < 31'd10), "front: units remainder out of range")

endmodule

`default_nettype wire

/* hdl/itwt_queue.sv */
// ----------------------------------------------------------------------------
// itwt_queue: short item queue
// Two-entry queue that parts the digit pipeline from the token emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module itwt_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire itwt_pkg::f2q_t   q_in,
	output logic                  q_ready,
	output itwt_pkg::q2b_t        head,
	input  wire logic             pop
);

	localparam int unsigned CNT_W = $clog2(itwt_pkg::QDEPTH + 1);
	localparam int unsigned PTR_W = $clog2(itwt_pkg::QDEPTH);

	itwt_pkg::digits_t  q_mem_q [itwt_pkg::QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               full;
	logic               push;

	// A full queue still takes an item in the cycle that its head leaves.
	assign full    = (count_q == CNT_W'(itwt_pkg::QDEPTH));
	assign q_ready = !full || pop;
	assign push    = q_in.vld && q_ready;

	assign head.vld    = (count_q != '0);
	assign head.digits = q_mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(itwt_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(itwt_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= q_in.digits;
	end

	`ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(itwt_pkg::QDEPTH), "queue: fill count beyond depth")
	`ASSERT_IMPL(a_push_full, push && full, pop, "queue: item written into a full queue")

endmodule

`default_nettype wire

/* hdl/itwt_back.sv */
// ----------------------------------------------------------------------------
// itwt_back: word token emitter
// Lays the ten digits of the head item out as twenty token slots and sends
// the valid slots, or Zero if none is valid, one token per cycle, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module itwt_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire itwt_pkg::q2b_t                head,
	output logic                               pop,
	output logic                               strobe,
	output logic [itwt_pkg::WORD_W-1:0]        word,
	output logic                               last
);

	localparam int unsigned NS = itwt_pkg::NSLOTS;
	localparam int unsigned GS = itwt_pkg::GSLOTS;

	logic [itwt_pkg::WORD_W-1:0] tok [NS];
	logic [NS-1:0]               msk;
	logic [NS-1:0]               cur;
	logic [NS-1:0]               pick;
	logic [NS-1:0]               nxt;
	logic [NS-1:0]               rem_q;
	logic                        act_q;
	logic                        strobe_q;
	logic                        last_q;
	logic [itwt_pkg::WORD_W-1:0] word_q;
	logic [itwt_pkg::WORD_W-1:0] sel_tok;
	logic                        emit;
	logic                        all_zero;
	logic [itwt_pkg::NDIGITS+1:0][3:0] dpad;

	// Two zero digits above the billions digit give every group three digits.
	assign dpad = {8'h00, head.digits};

	// Slots of each group: hundreds digit, Hundred, tens or teen word, unit, scale.
	always_comb begin
		logic [3:0] h;
		logic [3:0] t;
		logic [3:0] u;
		for (int g = 0; g < int'(itwt_pkg::NGROUPS); g++) begin
			h = dpad[11 - 3*g];
			t = dpad[10 - 3*g];
			u = dpad[9 - 3*g];
			tok[g*GS + 0] = {1'b0, h};
			tok[g*GS + 1] = itwt_pkg::TOK_HUNDRED;
			if (t == 4'd1) tok[g*GS + 2] = itwt_pkg::TOK_TEN + {1'b0, u};
			else           tok[g*GS + 2] = itwt_pkg::TOK_TWENTY + {1'b0, t} - 5'd2;
			tok[g*GS + 3] = {1'b0, u};
			case (g)
				0:       tok[g*GS + 4] = itwt_pkg::TOK_BILLION;
				1:       tok[g*GS + 4] = itwt_pkg::TOK_MILLION;
				default: tok[g*GS + 4] = itwt_pkg::TOK_THOUSAND;
			endcase
			msk[g*GS + 0] = (h != '0);
			msk[g*GS + 1] = (h != '0);
			msk[g*GS + 2] = (t != '0);
			msk[g*GS + 3] = (t != 4'd1) && (u != '0);
			msk[g*GS + 4] = (g != int'(itwt_pkg::NGROUPS) - 1) &&
					((h != '0) || (t != '0) || (u != '0));
		end
	end

	// Lowest pending slot goes out next.
	assign all_zero = (msk == '0);
	assign cur      = act_q ? rem_q : msk;
	assign pick     = cur & (~cur + 1'b1);
	assign nxt      = cur & ~pick;

	always_comb begin
		sel_tok = '0;
		for (int i = 0; i < int'(NS); i++) begin
			if (pick[i]) sel_tok = sel_tok | tok[i];
		end
	end

	assign emit = head.vld;
	assign pop  = head.vld && (all_zero || (nxt == '0));

	// Slot bookkeeping across the tokens of one item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (emit) act_q <= !pop;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (emit) begin
			rem_q  <= nxt;
			word_q <= all_zero ? itwt_pkg::TOK_ZERO : sel_tok;
			last_q <= pop;
		end
	end

	assign strobe = strobe_q;
	assign word   = word_q;
	assign last   = last_q;

	`ASSERT_IMPL(a_pop_valid, pop, head.vld, "back: pop with an empty queue")
	`ASSERT_IMPL(a_zero_alone, strobe_q && (word_q == itwt_pkg::TOK_ZERO), last_q, "back: Zero token not alone")

endmodule

`default_nettype wire
